// ----- sv/rir_pkg.sv -----
// Shared package for the table-driven random-in-range block.
// Holds field widths, opcode and path codes, and the transfer struct types.
// No dependencies.
package rir_pkg;

  localparam int DATA_W          = 8;
  localparam int OPCODE_W        = 2;
  localparam int PATH_W          = 2;
  localparam int TABLE_DEPTH_DEF = 256;

  // Opcodes of an input item.
  localparam logic [OPCODE_W-1:0] OP_WRITE     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_INDEX = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DRAW      = 2'd2;

  // Which way a draw was resolved.
  localparam logic [PATH_W-1:0] PATH_BYPASS = 2'd0;
  localparam logic [PATH_W-1:0] PATH_RAW    = 2'd1;
  localparam logic [PATH_W-1:0] PATH_MODULO = 2'd2;

  localparam logic [DATA_W-1:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_ZERO     = 8'h00;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   range_low;
    logic [DATA_W-1:0]   range_high;
    logic [DATA_W-1:0]   entry_address;
    logic [DATA_W-1:0]   entry_value;
    logic [DATA_W-1:0]   new_index;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] random_value;
    logic [PATH_W-1:0] draw_path;
  } out_item_t;

endpackage

// ----- sv/table_random_in_range.sv -----
// Top level of the table-driven random-in-range block.
// Depends on rir_pkg, rir_table and rir_div.
//
// The block holds a 256-entry table of random bytes and a wrapping read index.
// A write-entry or set-index item is taken without a stall and returns nothing.
// A draw returns one result: a bypassed draw goes from IDLE to EMIT, a
// full-range draw through FETCH to EMIT, and a reduced draw through FETCH,
// DIVIDE and EMIT, where the bit-serial remainder unit retires one dividend
// bit per cycle; EMIT loads the result into the output register. Input is
// stalled from a draw's transfer until its result enters the output register
// (EMIT waits while the output stalls). One item is worked on at a time; a
// new item is taken while an earlier result still waits at the output. The
// table has no reset: a draw must only read entries written before.
module table_random_in_range
  import rir_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [DATA_W-1:0] read_index;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] hi;
  logic [DATA_W-1:0] result;
  logic [PATH_W-1:0] path;

  logic              in_xfer;
  logic              out_free;
  logic              bypass;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] entry;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DATA_W-1:0] div_rem;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Bounds that return the upper bound unchanged.
  assign bypass = (in_item.range_low == BYTE_ALL_ONES) ||
                  (in_item.range_high == BYTE_ZERO) ||
                  (in_item.range_high == in_item.range_low);
  assign span      = hi - lo;
  assign div_start = (state == S_FETCH) && (span != BYTE_ALL_ONES);

  rir_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_xfer && (in_item.opcode == OP_WRITE)),
    .wr_addr (in_item.entry_address[AW-1:0]),
    .wr_data (in_item.entry_value),
    .rd_addr (read_index[AW-1:0]),
    .rd_data (entry)
  );

  rir_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (entry),
    .divisor   (span + 1'b1),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && (in_item.opcode == OP_DRAW)) begin
          state_next = bypass ? S_EMIT : S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = div_start ? S_DIVIDE : S_EMIT;
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      read_index <= '0;
    end else begin
      state <= state_next;
      if (in_xfer && (in_item.opcode == OP_SET_INDEX)) begin
        read_index <= in_item.new_index;
      end else if ((state == S_DIVIDE) && div_done) begin
        read_index <= read_index + 1'b1;
      end
    end
  end

  // Draw operands and result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      lo     <= in_item.range_low;
      hi     <= in_item.range_high;
      result <= in_item.range_high;
      path   <= PATH_BYPASS;
    end else if ((state == S_FETCH) && !div_start) begin
      result <= entry;
      path   <= PATH_RAW;
    end else if ((state == S_DIVIDE) && div_done) begin
      result <= div_rem + lo;
      path   <= PATH_MODULO;
    end
  end

  // Output register: a result is held until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_item.random_value <= result;
      out_item.draw_path    <= path;
    end
  end

`ifndef SYNTH
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVIDE))
    else $error("remainder finished outside the divide step");
  a_index_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (read_index != $past(read_index))) |->
    ($past(in_xfer && (in_item.opcode == OP_SET_INDEX)) ||
     $past((state == S_DIVIDE) && div_done)))
    else $error("read index changed without a set or a reduced draw");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("result not loaded into the output register");
  a_fetch_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state != S_FETCH))
    else $error("table fetch lasted more than one cycle");
  a_divide_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIVIDE) && !div_done) |-> div_busy)
    else $error("waiting on an idle remainder unit");
`endif

endmodule

// ----- sv/rir_table.sv -----
// Random byte table: one write port and one registered read port.
// Depends on rir_pkg for the data width.
module rir_table
  import rir_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/rir_div.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on rir_pkg for the data width.
module rir_div
  import rir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] remainder
);

  localparam int CW = $clog2(DATA_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(DATA_W - 1);

  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   trial;
  logic              fits;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    trial = {remainder, quo[DATA_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[DATA_W-2:0], 1'b0};
      if (fits) begin
        remainder <= DATA_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[DATA_W-1:0];
      end
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("remainder done without a running division");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dvs))
    else $error("remainder not below divisor");
`endif

endmodule

// ----- verif/rir_checker.sv -----
// Transfer monitor and result checker for the table-driven random-in-range block.
// Keeps its own copy of the random table and the read index and predicts each draw.
// Depends on rir_pkg.
module rir_checker
  import rir_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fails,
  output int        waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] rnd_bytes [TABLE_DEPTH_DEF];
  logic [DATA_W-1:0] draw_index;
  out_item_t         draw_q [$];
  int                errs = 0;

  // Work out one draw from its bounds and the table entry under the read index.
  function automatic out_item_t predict_draw(input logic [DATA_W-1:0] lo,
                                             input logic [DATA_W-1:0] hi,
                                             input logic [DATA_W-1:0] entry);
    out_item_t         r;
    logic [DATA_W-1:0] span;
    logic [DATA_W:0]   divisor;
    span = hi - lo;
    if (lo == BYTE_ALL_ONES || hi == BYTE_ZERO || hi == lo) begin
      r.random_value = hi;
      r.draw_path    = PATH_BYPASS;
    end else if (span == BYTE_ALL_ONES) begin
      r.random_value = entry;
      r.draw_path    = PATH_RAW;
    end else begin
      divisor        = {1'b0, span} + 1'b1;
      r.random_value = lo + DATA_W'(entry % divisor);
      r.draw_path    = PATH_MODULO;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      for (int k = 0; k < TABLE_DEPTH_DEF; k++) rnd_bytes[k] = '0;
      draw_index = '0;
      draw_q.delete();
    end else begin
      // Compare each result transfer with the oldest pending draw.
      if (out_valid && !out_stall) begin
        if (draw_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: value %02h path %0d",
                     out_item.random_value, out_item.draw_path);
        end else begin
          want = draw_q.pop_front();
          if (out_item.random_value !== want.random_value ||
              out_item.draw_path !== want.draw_path) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected value %02h path %0d, got value %02h path %0d",
                       want.random_value, want.draw_path,
                       out_item.random_value, out_item.draw_path);
          end
        end
      end

      // Update the shadow state on each input transfer.
      if (in_valid && !in_stall) begin
        case (in_item.opcode)
          OP_WRITE: begin
            rnd_bytes[in_item.entry_address] = in_item.entry_value;
          end
          OP_SET_INDEX: begin
            draw_index = in_item.new_index;
          end
          OP_DRAW: begin
            want = predict_draw(in_item.range_low, in_item.range_high,
                                rnd_bytes[draw_index]);
            if (want.draw_path == PATH_MODULO) draw_index = draw_index + 1'b1;
            draw_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fails   <= errs;
    waiting <= draw_q.size();
  end

endmodule

// ----- verif/table_random_in_range_tb.sv -----
// Testbench top for the table-driven random-in-range block.
// Drives directed and random transfers with idle and stall phases; rir_checker judges results.
// Depends on rir_pkg, rir_checker and table_random_in_range.
module table_random_in_range_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rir_pkg::*;

  // The one opcode that the block ignores.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fails;
  int        waiting;

  int                idle_pct  = 0;
  int                stall_pct = 0;
  bit                written [TABLE_DEPTH_DEF];
  logic [DATA_W-1:0] cur_index = '0;

  table_random_in_range dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  rir_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .fails     (fails),
    .waiting   (waiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // A draw reads the table unless its bounds take the bypass.
  function automatic bit reads_table(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    return !(lo == BYTE_ALL_ONES || hi == BYTE_ZERO || hi == lo);
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom(), $urandom()};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // Track which entries hold data and where the read index stands, then
  // present the item until its transfer.
  task automatic issue(input in_item_t it);
    logic [DATA_W-1:0] span;
    span = it.range_high - it.range_low;
    case (it.opcode)
      OP_WRITE:     written[it.entry_address] = 1'b1;
      OP_SET_INDEX: cur_index = it.new_index;
      OP_DRAW: begin
        if (reads_table(it.range_low, it.range_high) && span != BYTE_ALL_ONES)
          cur_index = cur_index + 1'b1;
      end
      default: ;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic do_write(input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] val);
    in_item_t it;
    it               = rand_item();
    it.opcode        = OP_WRITE;
    it.entry_address = addr;
    it.entry_value   = val;
    issue(it);
  endtask

  task automatic do_set_index(input logic [DATA_W-1:0] idx);
    in_item_t it;
    it           = rand_item();
    it.opcode    = OP_SET_INDEX;
    it.new_index = idx;
    issue(it);
  endtask

  task automatic do_draw(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    in_item_t it;
    it            = rand_item();
    it.opcode     = OP_DRAW;
    it.range_low  = lo;
    it.range_high = hi;
    issue(it);
  endtask

  // Random mix of writes, index loads and draws; ignored items are not counted.
  task automatic run_random(input int count);
    int                done;
    int                pick;
    in_item_t          it;
    logic [DATA_W-1:0] lo;
    done = 0;
    while (done < count) begin
      it   = rand_item();
      pick = $urandom_range(99);
      lo   = it.range_low;
      if (pick < 28) begin
        it.opcode = OP_WRITE;
      end else if (pick < 40) begin
        it.opcode = OP_SET_INDEX;
      end else if (pick < 95) begin
        it.opcode = OP_DRAW;
        case ($urandom_range(9))
          0: it.range_low = BYTE_ALL_ONES;
          1: it.range_high = BYTE_ZERO;
          2: it.range_high = lo;
          3: it.range_high = lo - 1'b1;
          4, 5: it.range_high = lo + DATA_W'($urandom_range(1, 7));
          default: ;
        endcase
      end else begin
        it.opcode = OP_UNUSED;
      end
      // Never let a draw read an entry that was not written since reset.
      if (it.opcode == OP_DRAW && reads_table(it.range_low, it.range_high) &&
          !written[cur_index]) begin
        it.opcode        = OP_WRITE;
        it.entry_address = cur_index;
      end
      issue(it);
      if (it.opcode != OP_UNUSED) done++;
    end
  endtask

  initial begin : stimulus
    in_item_t odd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: table extremes, every bypass case, both full-range
    // forms, reduced draws with wrap of the sum and of the index.
    do_write(8'd0, 8'hFF);
    do_write(8'd1, 8'h00);
    do_write(8'd2, 8'h80);
    do_write(8'd255, 8'h7F);
    do_write(8'd3, 8'hC5);
    do_draw(8'hFF, 8'hFF);
    do_draw(8'hFF, 8'h07);
    do_draw(8'h0A, 8'h00);
    do_draw(8'h00, 8'h00);
    do_draw(8'h40, 8'h40);
    do_draw(8'h00, 8'hFF);
    do_draw(8'h80, 8'h7F);
    do_draw(8'h00, 8'hFE);
    do_draw(8'h00, 8'h01);
    do_draw(8'hF0, 8'h20);
    do_draw(8'h05, 8'h06);
    do_set_index(8'hFF);
    do_draw(8'h00, 8'h10);
    do_draw(8'h00, 8'hFF);
    odd        = rand_item();
    odd.opcode = OP_UNUSED;
    issue(odd);
    do_draw(8'hFE, 8'hFF);
    do_set_index(8'h00);

    // Random part in four phases of input idling and output stalls.
    idle_pct = 0;  stall_pct = 0;  run_random(315);
    idle_pct = 56; stall_pct = 0;  run_random(315);
    idle_pct = 0;  stall_pct = 56; run_random(315);
    idle_pct = 25; stall_pct = 25; run_random(315);
    in_valid <= 1'b0;

    // Drain the outstanding draws, then allow the block to settle.
    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
